@@ hdl/ddar_pkg.sv @@
// shared types and codes for the dda line rasterizer
`default_nettype none

package ddar_pkg;

	// request kinds carried on the input tuser
	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;

	// status of the shared divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

@@ hdl/ddar_div.sv @@
// restoring divider, one quotient bit per cycle, for the rounded line increments
`default_nettype none

module ddar_div
	import ddar_pkg::*;
#(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [COORD_BITS-1:0]   mag,
	input  wire logic [COORD_BITS-1:0]   den,
	output logic      [FRAC_BITS:0]      quo,
	output div_status_t                  status
);

	localparam int NUM_W = COORD_BITS + FRAC_BITS + 1;
	localparam int CNT_W = $clog2(FRAC_BITS + 2);

	logic [NUM_W-1:0]      num;
	logic [COORD_BITS-1:0] rem_q;
	logic [FRAC_BITS:0]    sh_q;
	logic [COORD_BITS-1:0] den_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COORD_BITS+1:0] diff;
	logic                  fits;

	// dividend is mag scaled by the fraction plus half the divisor for rounding
	assign num = {1'b0, mag, {FRAC_BITS{1'b0}}} + {{(FRAC_BITS + 2){1'b0}}, den[COORD_BITS-1:1]};

	// trial subtract of the divisor from the shifted partial remainder
	assign diff = {1'b0, rem_q, sh_q[FRAC_BITS]} - {2'b00, den_q};
	assign fits = ~diff[COORD_BITS+1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: high dividend bits seed the remainder, low bits shift out msb first
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:FRAC_BITS+1];
			sh_q  <= num[FRAC_BITS:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[COORD_BITS-1:0] : {rem_q[COORD_BITS-2:0], sh_q[FRAC_BITS]};
			sh_q  <= {sh_q[FRAC_BITS-1:0], fits};
		end
	end

	assign quo         = sh_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

`default_nettype wire

@@ hdl/dda_line_rasterizer.sv @@
// dda line rasterizer top level: request decode, position update, output register
//
// Input channel s_axis: tuser is the request kind (start or advance), tdata the
// two endpoints. A start item loads the first endpoint and emits it as the first
// pixel; the increments are then found by the shared bit-serial divider, first
// for x and then for y, one quotient bit per cycle. A start with distinct
// endpoints therefore holds tready low after the accept until both increments
// are in; equal endpoints emit one pixel flagged last and start no division.
// Each advance item emits the next pixel; the final pixel of a line carries
// tlast. An advance with no line in progress is accepted and gives no pixel.
// Output channel m_axis: one registered pixel, visible the cycle after its item
// is accepted. While the receiver stalls the pixel holds and tready on the input
// stays low; a pixel taken in the same cycle frees the register for a new item.
// Reset clears the sequencer, the output valid and the active-line flag.
`default_nettype none

module dda_line_rasterizer
	import ddar_pkg::*;
#(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	// start_x, start_y, end_x, end_y from bit 0 up
	input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
	// req_type
	input  wire logic                                   s_axis_tuser,
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	// pixel_x, pixel_y from bit 0 up
	output logic      [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
	output logic                                        m_axis_tlast
);

	localparam int OUT_W  = ((2*COORD_BITS+7)/8)*8;
	localparam int POS_W  = COORD_BITS + FRAC_BITS;
	localparam int STEP_W = POS_W + 1;
	localparam int SUM_W  = POS_W + 2;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_WAIT_X = 2'd1;
	localparam logic [1:0] ST_WAIT_Y = 2'd2;

	logic [1:0]            state_q;
	logic                  line_active_q;
	logic [COORD_BITS-1:0] steps_left_q;
	logic [POS_W-1:0]      pos_x_q, pos_y_q;
	logic [STEP_W-1:0]     step_x_q, step_y_q;
	logic [COORD_BITS-1:0] mag_y_q;
	logic                  neg_x_q, neg_y_q;
	logic                  m_valid_q, m_last_q;
	logic [COORD_BITS-1:0] m_x_q, m_y_q;

	logic [COORD_BITS-1:0] x0, y0, x1, y1;
	logic [COORD_BITS:0]   dx, dy;
	logic [COORD_BITS-1:0] ax, ay, steps;
	logic                  accept, is_start, is_adv;
	logic [SUM_W-1:0]      sum_x, sum_y;
	logic [POS_W-1:0]      nxt_x, nxt_y;
	logic [COORD_BITS-1:0] left_dec;

	logic                  div_start;
	logic [COORD_BITS-1:0] div_mag;
	logic [COORD_BITS-1:0] div_den;
	logic [FRAC_BITS:0]    div_quo;
	div_status_t           div_st;
	logic [STEP_W-1:0]     quo_ext, quo_signed;

	// field unpacking and handshake
	assign x0 = s_axis_tdata[COORD_BITS-1:0];
	assign y0 = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign x1 = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign y1 = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

	assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_start      = accept && (s_axis_tuser == REQ_START);
	assign is_adv        = accept && (s_axis_tuser == REQ_ADVANCE) && line_active_q;

	// deltas, magnitudes and step count
	assign dx    = {1'b0, x1} - {1'b0, x0};
	assign dy    = {1'b0, y1} - {1'b0, y0};
	assign ax    = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
	assign ay    = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
	assign steps = (ax > ay) ? ax : ay;

	// position advance with saturation to the coordinate range
	assign sum_x = {2'b00, pos_x_q} + {step_x_q[STEP_W-1], step_x_q};
	assign sum_y = {2'b00, pos_y_q} + {step_y_q[STEP_W-1], step_y_q};
	assign nxt_x = sum_x[SUM_W-1] ? '0 : (sum_x[POS_W] ? '1 : sum_x[POS_W-1:0]);
	assign nxt_y = sum_y[SUM_W-1] ? '0 : (sum_y[POS_W] ? '1 : sum_y[POS_W-1:0]);
	assign left_dec = steps_left_q - COORD_BITS'(1);

	// shared divider: x launches on the start accept, y when x is done
	assign div_start = (is_start && (steps != '0)) || ((state_q == ST_WAIT_X) && div_st.done);
	assign div_mag   = (state_q == ST_WAIT_X) ? mag_y_q : ax;
	// the step count is not registered yet on the start accept
	assign div_den   = (state_q == ST_IDLE) ? steps : steps_left_q;

	ddar_div #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (div_mag),
		.den    (div_den),
		.quo    (div_quo),
		.status (div_st)
	);

	// apply the sign of the delta to the quotient
	assign quo_ext    = {{COORD_BITS{1'b0}}, div_quo};
	assign quo_signed = ((state_q == ST_WAIT_X) ? neg_x_q : neg_y_q) ? -quo_ext : quo_ext;

	// sequencer and line control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			line_active_q <= 1'b0;
			steps_left_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (is_start) begin
						line_active_q <= 1'b0;
						steps_left_q  <= steps;
						if (steps != '0) begin
							state_q <= ST_WAIT_X;
						end
					end else if (is_adv) begin
						steps_left_q <= left_dec;
						if (left_dec == '0) begin
							line_active_q <= 1'b0;
						end
					end
				end
				ST_WAIT_X: begin
					if (div_st.done) begin
						state_q <= ST_WAIT_Y;
					end
				end
				ST_WAIT_Y: begin
					if (div_st.done) begin
						state_q       <= ST_IDLE;
						line_active_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// position, increments and captured deltas
	always_ff @(posedge clk) begin
		if (is_start) begin
			pos_x_q  <= {x0, 1'b1, {(FRAC_BITS-1){1'b0}}};
			pos_y_q  <= {y0, 1'b1, {(FRAC_BITS-1){1'b0}}};
			mag_y_q  <= ay;
			neg_x_q  <= dx[COORD_BITS];
			neg_y_q  <= dy[COORD_BITS];
			step_x_q <= '0;
			step_y_q <= '0;
		end else if (is_adv) begin
			pos_x_q <= nxt_x;
			pos_y_q <= nxt_y;
		end
		if ((state_q == ST_WAIT_X) && div_st.done) begin
			step_x_q <= quo_signed;
		end
		if ((state_q == ST_WAIT_Y) && div_st.done) begin
			step_y_q <= quo_signed;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (is_start || is_adv) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_start) begin
			m_x_q    <= x0;
			m_y_q    <= y0;
			m_last_q <= (steps == '0);
		end else if (is_adv) begin
			m_x_q    <= nxt_x[POS_W-1:FRAC_BITS];
			m_y_q    <= nxt_y[POS_W-1:FRAC_BITS];
			m_last_q <= (left_dec == '0);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = OUT_W'({m_y_q, m_x_q});

	// checks
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready)
		else $error("input ready while increments are being computed");

	a_active_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> (steps_left_q != '0))
		else $error("active line with no steps left");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> ((state_q == ST_WAIT_X) || (state_q == ST_WAIT_Y)))
		else $error("divider finished outside a wait state");

	a_start_launches: assert property (@(posedge clk) disable iff (!arst_n)
		(is_start && (steps != '0)) |=> ((state_q == ST_WAIT_X) && div_st.busy))
		else $error("start with distinct endpoints did not launch the divider");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider launched while busy");

endmodule

`default_nettype wire
